FILE: rtl/stgr_pkg.sv
`timescale 1ns / 1ps

package stgr_pkg;

  // Fixed widths of the stream fields and the configuration register.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned GS_W    = 5;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,  // waiting for input transfers
    ST_LOAD,  // first read of a run from the group buffer
    ST_SEND,  // a result sits in the output register
    ST_PEND   // final result of a run waits and the next run is queued
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // input transfer this cycle: store the value
    logic load;    // read the next run element into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;  // the offered input would close a run
    logic more;  // run elements remain to be loaded
  } dp_stat_t;

endpackage

FILE: rtl/stgr_ctrl.sv
`timescale 1ns / 1ps

module stgr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  stgr_pkg::dp_stat_t stat_i,
  output stgr_pkg::dp_cmd_t  cmd_o
);

  stgr_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stgr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.load   = 1'b0;
    unique case (state_q)
      stgr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.emit) begin
            state_d = stgr_pkg::ST_LOAD;
          end
        end
      end
      stgr_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = stgr_pkg::ST_SEND;
      end
      stgr_pkg::ST_SEND: begin
        out_valid_o = 1'b1;
        // Once the final result of a run is loaded, the buffer is free for
        // the next group.
        in_ready_o  = !stat_i.more;
        if (stat_i.more) begin
          if (out_ready_i) begin
            cmd_o.load = 1'b1;
          end
        end else if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.emit) begin
            state_d = out_ready_i ? stgr_pkg::ST_LOAD : stgr_pkg::ST_PEND;
          end else if (out_ready_i) begin
            state_d = stgr_pkg::ST_IDLE;
          end
        end else if (out_ready_i) begin
          state_d = stgr_pkg::ST_IDLE;
        end
      end
      stgr_pkg::ST_PEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = stgr_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = stgr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/stgr_datapath.sv
`timescale 1ns / 1ps

module stgr_datapath #(
  parameter int unsigned MAX_GROUP = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [stgr_pkg::GS_W-1:0]             group_size_i,
  input  logic signed [stgr_pkg::VALUE_W-1:0]   value_i,
  input  logic                                  end_of_list_i,
  output logic signed [stgr_pkg::VALUE_W-1:0]   value_out_o,
  output logic                                  last_of_run_o,
  output logic                                  list_done_o,
  input  stgr_pkg::dp_cmd_t                     cmd_i,
  output stgr_pkg::dp_stat_t                    stat_o
);

  localparam int unsigned AW = $clog2(MAX_GROUP);
  localparam int unsigned FW = $clog2(MAX_GROUP + 1);
  localparam int unsigned CW = (FW > stgr_pkg::GS_W) ? FW : stgr_pkg::GS_W;

  logic signed [stgr_pkg::VALUE_W-1:0] mem_q [MAX_GROUP];

  logic [stgr_pkg::GS_W-1:0] group_size_q;
  logic [FW-1:0]             fill_q;
  logic [FW-1:0]             rem_q;
  logic [AW-1:0]             rd_q;
  logic                      rev_q;
  logic                      last_q;

  logic [AW-1:0] wr_idx;
  logic [FW-1:0] fill_inc;
  logic [CW-1:0] k_eff;
  logic          full;

  logic signed [stgr_pkg::VALUE_W-1:0] value_out_q;
  logic                                last_of_run_q;
  logic                                list_done_q;

  // Write slot, saturated at the top entry.
  assign wr_idx   = (fill_q >= FW'(MAX_GROUP)) ? AW'(MAX_GROUP - 1) : fill_q[AW-1:0];
  assign fill_inc = FW'(wr_idx) + FW'(1);

  always_comb begin
    if (group_size_q == '0) begin
      k_eff = CW'(1);
    end else if (CW'(group_size_q) > CW'(MAX_GROUP)) begin
      k_eff = CW'(MAX_GROUP);
    end else begin
      k_eff = CW'(group_size_q);
    end
  end

  assign full        = CW'(fill_inc) >= k_eff;
  assign stat_o.emit = full || end_of_list_i;
  assign stat_o.more = rem_q != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= stgr_pkg::GS_W'(1);
    end else if (cfg_valid_i) begin
      group_size_q <= group_size_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem_q[wr_idx] <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rem_q  <= '0;
      rd_q   <= '0;
      rev_q  <= 1'b0;
      last_q <= 1'b0;
    end else if (cmd_i.accept) begin
      if (stat_o.emit) begin
        fill_q <= '0;
        rem_q  <= fill_inc;
        rev_q  <= full;
        last_q <= end_of_list_i;
        rd_q   <= full ? wr_idx : '0;
      end else begin
        fill_q <= fill_inc;
      end
    end else if (cmd_i.load) begin
      rem_q <= rem_q - FW'(1);
      rd_q  <= rev_q ? (rd_q - AW'(1)) : (rd_q + AW'(1));
    end
  end

  // The registered read port doubles as the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_out_q   <= mem_q[rd_q];
      last_of_run_q <= rem_q == FW'(1);
      list_done_q   <= (rem_q == FW'(1)) && last_q;
    end
  end

  assign value_out_o   = value_out_q;
  assign last_of_run_o = last_of_run_q;
  assign list_done_o   = list_done_q;

  a_load_has_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> rem_q != '0)
    else $error("load issued with no run elements left");

  a_emit_starts_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && stat_o.emit) |=> (fill_q == '0) && (rem_q != '0))
    else $error("closing transfer did not start a run");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < FW'(MAX_GROUP))
    else $error("group buffer fill count out of range");

endmodule

FILE: rtl/stream_group_reverser.sv
`timescale 1ns / 1ps

// Stream group reverser.
// Input channel (in_valid_i / in_ready_o) carries one signed list element per
// transfer, with end_of_list_i marking the final element of a list. Elements
// collect in a group buffer. When group_size elements are held, they leave on
// the output channel (out_valid_o / out_ready_i) in reverse order as one run;
// a short tail group closed by end_of_list_i leaves in original order. A
// group_size of 0 or 1 passes each element through, values above MAX_GROUP
// act as MAX_GROUP. last_of_run_o flags the final result of each run, and
// list_done_o the final result of the whole list.
// The configuration channel (cfg_valid_i / cfg_ready_o) is always ready and
// must only be used while the block is idle.
// After the closing input transfer, the LOAD state reads the first result of
// a run into the output register; then one result per cycle follows while
// the receiver takes them. A group passes through its input transfers, LOAD
// and its output transfers; input waits while run elements remain in the
// single group buffer, and the next group's first transfer shares the last
// output cycle. While the final result of a run waits, the next group is
// already accepted. If the receiver stalls, results hold in the output
// register and input stalls once a further run is queued. Reset empties the
// buffer and sets group_size to 1; buffer contents are not cleared.
module stream_group_reverser #(
  parameter int unsigned MAX_GROUP = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [stgr_pkg::GS_W-1:0]           group_size_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [stgr_pkg::VALUE_W-1:0] value_i,
  input  logic                                end_of_list_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [stgr_pkg::VALUE_W-1:0] value_out_o,
  output logic                                last_of_run_o,
  output logic                                list_done_o
);

  stgr_pkg::dp_cmd_t  cmd;
  stgr_pkg::dp_stat_t stat;

  // The register accepts a write in any cycle.
  assign cfg_ready_o = 1'b1;

  stgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  stgr_datapath #(
    .MAX_GROUP (MAX_GROUP)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .group_size_i  (group_size_i),
    .value_i       (value_i),
    .end_of_list_i (end_of_list_i),
    .value_out_o   (value_out_o),
    .last_of_run_o (last_of_run_o),
    .list_done_o   (list_done_o),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MAX_GROUP   = 16;
  // Cycles to let pass after the last awaited element before touching the
  // configuration, since an element that closes no run leaves nothing to wait on.
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 20;

  // One result transfer as seen on the output channel.
  typedef struct packed {
    logic signed [stgr_pkg::VALUE_W-1:0] value;
    logic                                last_of_run;
    logic                                list_done;
  } element_t;

  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_e;

  // One row of the directed stimulus. A row with a typed result carries the
  // single element that it must produce, written out by hand.
  typedef struct {
    row_kind_e                    kind;
    logic [stgr_pkg::VALUE_W-1:0] data;
    logic                         eol;
    bit                           typed;
    element_t                     want;
  } stim_row_t;

  logic                                clk;
  logic                                rst_ni;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [stgr_pkg::GS_W-1:0]           group_size_i;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic signed [stgr_pkg::VALUE_W-1:0] value_i;
  logic                                end_of_list_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic signed [stgr_pkg::VALUE_W-1:0] value_out_o;
  logic                                last_of_run_o;
  logic                                list_done_o;

  // Shadow of the block: group buffer, fill level and the group size register.
  logic [stgr_pkg::VALUE_W-1:0] grp_buf [MAX_GROUP];
  int unsigned                  grp_fill;
  int unsigned                  grp_size;

  element_t    awaited_elements[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;

  stream_group_reverser #(
    .MAX_GROUP(MAX_GROUP)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .group_size_i  (group_size_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .end_of_list_i (end_of_list_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_out_o   (value_out_o),
    .last_of_run_o (last_of_run_o),
    .list_done_o   (list_done_o)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The run is cut off here if the block hangs or loses an element.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Appends one element to the shadow buffer and queues whatever run it
  // closes. A full group leaves reversed; a short group closed by the end of
  // the list leaves in arrival order. Sizes 0 and 1 act as pass-through, and
  // sizes above MAX_GROUP act as MAX_GROUP.
  function automatic void regroup_element(logic [stgr_pkg::VALUE_W-1:0] v, logic eol);
    int unsigned k;
    int unsigned n;
    bit          reverse;
    element_t    e;
    k = (grp_size > MAX_GROUP) ? MAX_GROUP : grp_size;
    if (k < 1) k = 1;
    if (grp_fill >= MAX_GROUP) grp_fill = MAX_GROUP - 1;
    grp_buf[grp_fill] = v;
    grp_fill++;
    if (grp_fill >= k) reverse = 1'b1;
    else if (eol) reverse = 1'b0;
    else return;
    n = grp_fill;
    for (int unsigned i = 0; i < n; i++) begin
      e.value       = grp_buf[reverse ? (n - 1 - i) : i];
      e.last_of_run = (i == n - 1);
      e.list_done   = (i == n - 1) && eol;
      awaited_elements.push_back(e);
    end
    grp_fill = 0;
  endfunction

  task automatic report_mismatch(string what, logic [stgr_pkg::VALUE_W-1:0] got,
                                 logic [stgr_pkg::VALUE_W-1:0] want);
    $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  // Every output transfer is checked against the oldest awaited element.
  always @(posedge clk) begin : check_results
    element_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_elements.size() == 0) begin
        report_mismatch("result with nothing awaited", value_out_o, '0);
      end else begin
        want = awaited_elements.pop_front();
        if (value_out_o !== want.value)
          report_mismatch("value_out", value_out_o, want.value);
        if (last_of_run_o !== want.last_of_run)
          report_mismatch("last_of_run", stgr_pkg::VALUE_W'(last_of_run_o),
                          stgr_pkg::VALUE_W'(want.last_of_run));
        if (list_done_o !== want.list_done)
          report_mismatch("list_done", stgr_pkg::VALUE_W'(list_done_o),
                          stgr_pkg::VALUE_W'(want.list_done));
      end
    end
  end

  // Receiver side. A pending hold-off keeps ready low for a counted number of
  // cycles; otherwise ready drops at random according to the current mix.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one element and waits for its transfer. Valid stays high afterwards;
  // the caller either drives the next element or drops valid at the next
  // falling edge, so the accepted element is never offered twice.
  task automatic send_element(logic [stgr_pkg::VALUE_W-1:0] v, logic eol);
    @(negedge clk);
    in_valid_i    <= 1'b1;
    value_i       <= v;
    end_of_list_i <= eol;
    do @(posedge clk); while (!in_ready_o);
    regroup_element(v, eol);
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  endtask

  // Stops offering elements and waits until every awaited element has left,
  // then lets the block settle in case it still works on a partial group.
  task automatic settle_outputs();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (awaited_elements.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_group_size(logic [stgr_pkg::GS_W-1:0] gs);
    settle_outputs();
    @(negedge clk);
    cfg_valid_i  <= 1'b1;
    group_size_i <= gs;
    do @(posedge clk); while (!cfg_ready_o);
    grp_size = 32'(gs);
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [stgr_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly small groups so that runs close often, with a few pass-through,
  // full-size, mid-size and oversized settings mixed in.
  function automatic logic [stgr_pkg::GS_W-1:0] pick_group_size();
    case ($urandom_range(9))
      6: return stgr_pkg::GS_W'($urandom_range(0, 1));
      7: return stgr_pkg::GS_W'(MAX_GROUP);
      8: return stgr_pkg::GS_W'($urandom_range(MAX_GROUP + 1, 31));
      9: return stgr_pkg::GS_W'($urandom_range(7, MAX_GROUP - 1));
      default: return stgr_pkg::GS_W'($urandom_range(2, 6));
    endcase
  endfunction

  task automatic add_cfg(logic [stgr_pkg::GS_W-1:0] gs);
    stim_row_t r;
    r.kind  = ROW_CFG;
    r.data  = stgr_pkg::VALUE_W'(gs);
    r.eol   = 1'b0;
    r.typed = 1'b0;
    r.want  = '0;
    directed_rows.push_back(r);
  endtask

  task automatic add_item(logic [stgr_pkg::VALUE_W-1:0] v, logic eol);
    stim_row_t r;
    r.kind  = ROW_ITEM;
    r.data  = v;
    r.eol   = eol;
    r.typed = 1'b0;
    r.want  = '0;
    directed_rows.push_back(r);
  endtask

  // Pass-through rows: the element comes straight back, closing its own run.
  task automatic add_echo(logic [stgr_pkg::VALUE_W-1:0] v, logic eol);
    stim_row_t r;
    r.kind  = ROW_ITEM;
    r.data  = v;
    r.eol   = eol;
    r.typed = 1'b1;
    r.want  = '{value: v, last_of_run: 1'b1, list_done: eol};
    directed_rows.push_back(r);
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    logic        eol;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    group_size_i  = '0;
    in_valid_i    = 1'b0;
    value_i       = '0;
    end_of_list_i = 1'b0;
    out_ready_i   = 1'b0;
    mismatches    = 0;
    cycles        = 0;
    hold_left     = 0;
    send_idle_pct = 24;
    recv_idle_pct = 77;
    grp_fill      = 0;
    grp_size      = 1;
    foreach (grp_buf[i]) grp_buf[i] = '0;

    // Reset group size is 1, so the first elements simply pass through.
    add_echo(32'h7FFF_FFFF, 1'b0);
    add_echo(32'h8000_0000, 1'b1);
    add_echo(32'h0000_0000, 1'b0);
    add_echo(32'hFFFF_FFFF, 1'b1);
    // A group size of zero also passes through.
    add_cfg(stgr_pkg::GS_W'(0));
    add_echo(32'h0000_0005, 1'b0);
    // Full group reversed, then a short tail kept in order, then a full
    // group that also ends the list.
    add_cfg(stgr_pkg::GS_W'(3));
    add_item(32'd1, 1'b0);
    add_item(32'd2, 1'b0);
    add_item(32'd3, 1'b0);
    add_item(32'd4, 1'b0);
    add_item(32'd5, 1'b1);
    add_item(32'd6, 1'b0);
    add_item(32'd7, 1'b0);
    add_item(32'd8, 1'b1);
    // An oversized setting acts as the largest group; a short list stays in order.
    add_cfg(stgr_pkg::GS_W'(31));
    add_item(32'hA5A5_A5A5, 1'b0);
    add_item(32'h5A5A_5A5A, 1'b1);
    // Lowering the group size below the fill level: the next element flushes
    // the whole buffer reversed.
    add_cfg(stgr_pkg::GS_W'(5));
    add_item(32'd10, 1'b0);
    add_item(32'd11, 1'b0);
    add_item(32'd12, 1'b0);
    add_cfg(stgr_pkg::GS_W'(2));
    add_item(32'd13, 1'b0);
    // A one-element list at the largest group size.
    add_cfg(stgr_pkg::GS_W'(MAX_GROUP));
    add_item(32'hDEAD_BEEF, 1'b1);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_group_size(directed_rows[i].data[stgr_pkg::GS_W-1:0]);
      end else begin
        send_element(directed_rows[i].data, directed_rows[i].eol);
        if (directed_rows[i].typed)
          awaited_elements[awaited_elements.size() - 1] = directed_rows[i].want;
      end
    end

    // Random lists in three idling mixes, three group sizes each. Lists are
    // mostly well formed; a stray end flag now and then breaks one early, and
    // a phase may end mid-list so the next size change lands mid-group.
    for (int unsigned mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int unsigned ph = 0; ph < 3; ph++) begin
        write_group_size(pick_group_size());
        // With the sender offering every cycle, a long receiver hold-off
        // fills the block until it stalls its input.
        if (mode == 2 && ph == 0) hold_left = 300;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
          len = $urandom_range(1, 12);
          for (int unsigned j = 0; j < len && sent < PHASE_ITEMS; j++) begin
            eol = (j == len - 1) || ($urandom_range(9) == 0);
            // Once, the sender waits, possibly mid-list, until everything has drained.
            if (mode == 1 && ph == 1 && sent == 12) settle_outputs();
            send_element(pick_value(), eol);
            sender_gap();
            sent++;
          end
        end
      end
    end

    settle_outputs();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/stgr_pkg.sv
rtl/stgr_ctrl.sv
rtl/stgr_datapath.sv
rtl/stream_group_reverser.sv
tb/tb_top.sv
